FILE: rtl/mac_roman_to_utf8_encoder_assert.svh
`ifndef MAC_ROMAN_TO_UTF8_ENCODER_ASSERT_SVH
`define MAC_ROMAN_TO_UTF8_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mre_pkg.sv
package mre_pkg;

  // replacement for control codes
  localparam logic [7:0] QMARK_BYTE = 8'h3F;
  localparam logic [7:0] DEL_CODE   = 8'h7F;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] LEAD2_BYTE = 8'hC0;
  localparam logic [7:0] LEAD3_BYTE = 8'hE0;
  localparam logic [7:0] CONT_BYTE  = 8'h80;

  // index of the final byte of a character
  localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
  localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
  localparam logic [1:0] LAST_IDX_THREE = 2'd2;

  // encoded character: byte 0 goes out first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  // unicode code points for mac roman 0x80 .. 0xff
  localparam logic [15:0] UPPER_CP [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h00A4, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

endpackage

FILE: rtl/mre_if.sv
// input channel: one mac roman character per transaction
interface mre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] mac_byte;
  logic       name_end;

  modport source (output valid, output mac_byte, output name_end, input ready);
  modport sink   (input valid, input mac_byte, input name_end, output ready);
endinterface

// result channel: one utf-8 byte per transaction
interface mre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       char_done;
  logic       name_done;

  modport source (output valid, output utf8_byte, output char_done, output name_done,
                  input ready);
  modport sink   (input valid, input utf8_byte, input char_done, input name_done,
                  output ready);
endinterface

FILE: rtl/mre_encode.sv
module mre_encode (
  input  logic [7:0]    mac_byte,
  output mre_pkg::enc_t enc
);
  import mre_pkg::*;

  logic [15:0] cp;
  logic        is_ctrl;

  // table lookup for the upper half
  assign cp      = UPPER_CP[mac_byte[6:0]];
  assign is_ctrl = (mac_byte < SPACE_CODE) || (mac_byte == DEL_CODE);

  // build the one to three utf-8 bytes
  always_comb begin
    enc.bytes    = '0;
    enc.last_idx = LAST_IDX_ONE;
    if (!mac_byte[7]) begin
      enc.bytes[0] = is_ctrl ? QMARK_BYTE : mac_byte;
    end else if (cp[15:11] == 5'd0) begin
      enc.bytes[0] = LEAD2_BYTE | {3'd0, cp[10:6]};
      enc.bytes[1] = CONT_BYTE | {2'd0, cp[5:0]};
      enc.last_idx = LAST_IDX_TWO;
    end else begin
      enc.bytes[0] = LEAD3_BYTE | {4'd0, cp[15:12]};
      enc.bytes[1] = CONT_BYTE | {2'd0, cp[11:6]};
      enc.bytes[2] = CONT_BYTE | {2'd0, cp[5:0]};
      enc.last_idx = LAST_IDX_THREE;
    end
  end

endmodule

FILE: rtl/mac_roman_to_utf8_encoder.sv
// Mac Roman to UTF-8 encoder. Each input transaction carries one Mac Roman
// code and the end-of-name flag; the block answers with one byte (ASCII, or
// '?' for control codes), two bytes (code points below U+0800) or three bytes
// per character, one byte per output transaction, with char_done on the final
// byte and name_done on the final byte of the last character. The input is
// registered, then the character is encoded into a byte register that drains
// one byte per cycle while the output is ready, so the output port sets the
// sustained rate (one ASCII character per cycle). An accepted character passes
// the input register and the encoded character register before its first byte
// appears on the output. A new character is taken while the previous one is
// still draining.
module mac_roman_to_utf8_encoder (
  input  logic       clk,
  input  logic       rst_n,
  mre_in_if.sink     in_ch,
  mre_out_if.source  out_ch
);
  import mre_pkg::*;

  // input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // encoded character stage
  logic       s2_valid_r, s2_valid_nxt;
  enc_t       s2_enc_r;
  logic       s2_end_r;
  logic [1:0] s2_idx_r, s2_idx_nxt;

  enc_t       enc;
  logic       out_last;
  logic       s2_free;

  mre_encode u_encode (
    .mac_byte (s1_byte_r),
    .enc      (enc)
  );

  // handshake between the stages
  assign out_last    = (s2_idx_r == s2_enc_r.last_idx);
  assign s2_free     = !s2_valid_r || (out_ch.ready && out_last);
  assign in_ch.ready = !s1_valid_r || s2_free;

  // next-state logic
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    s2_idx_nxt   = s2_idx_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r;
      s2_idx_nxt   = 2'd0;
    end else if (out_ch.ready) begin
      s2_idx_nxt = s2_idx_r + 2'd1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_idx_r   <= 2'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s2_idx_r   <= s2_idx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.mac_byte;
      s1_end_r  <= in_ch.name_end;
    end
    if (s2_free && s1_valid_r) begin
      s2_enc_r <= enc;
      s2_end_r <= s1_end_r;
    end
  end

  // output byte select
  assign out_ch.valid     = s2_valid_r;
  assign out_ch.utf8_byte = s2_enc_r.bytes[s2_idx_r];
  assign out_ch.char_done = out_last;
  assign out_ch.name_done = out_last && s2_end_r;

endmodule

FILE: rtl/mre_checker.sv
`include "mac_roman_to_utf8_encoder_assert.svh"

module mre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_utf8_byte,
  input logic       out_char_done,
  input logic       out_name_done
);
  import mre_pkg::*;

  logic out_fire;
  logic out_stall;
  logic out_cont;
  logic out_ctrl;

  // handshake and byte class terms
  assign out_fire  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_cont  = (out_utf8_byte[7:6] == 2'b10);
  assign out_ctrl  = (out_utf8_byte < SPACE_CODE) || (out_utf8_byte == DEL_CODE);

  // a stalled output transaction keeps its byte
  `MRE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_utf8_byte), "held byte changed")

  // end of name only on the final byte of a character
  `MRE_ASSERT_NOW(a_name_on_char, out_valid && out_name_done, out_char_done, "early name_done")

  // a byte that is not final is a lead or continuation byte
  `MRE_ASSERT_NOW(a_mid_byte, out_valid && !out_char_done, out_utf8_byte[7], "ascii mid character")

  // a character never starts with a continuation byte
  `MRE_ASSERT_NEXT(a_char_start, out_fire && out_char_done, !out_valid || !out_cont, "bad lead")

  // control codes never reach the output
  `MRE_ASSERT_NOW(a_no_ctrl, out_valid, !out_ctrl, "control code on output")

endmodule

bind mac_roman_to_utf8_encoder mre_checker u_mre_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_utf8_byte (out_ch.utf8_byte),
  .out_char_done (out_ch.char_done),
  .out_name_done (out_ch.name_done)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mre_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  mre_in_if  in_ch ();
  mre_out_if out_ch ();

  mac_roman_to_utf8_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock, 2 ns period
  always #1 clk = ~clk;

  // unicode code points for the upper half of mac roman, 0x80 .. 0xff
  localparam logic [15:0] MAC_HIGH_CP [128] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h00A4, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       char_done;
    logic       name_done;
  } utf8_beat_t;

  // expected utf-8 byte stream and its comparison against the block
  class utf8_stream_checker;
    utf8_beat_t expected_bytes[$];
    int errors;
    int chars_seen;
    int names_seen;
    int bytes_checked;
    int ctrl_chars;
    int two_byte_chars;
    int three_byte_chars;

    function new();
      errors = 0;
      chars_seen = 0;
      names_seen = 0;
      bytes_checked = 0;
      ctrl_chars = 0;
      two_byte_chars = 0;
      three_byte_chars = 0;
    endfunction

    function void push_byte(logic [7:0] b, logic last, logic name_end);
      utf8_beat_t beat;
      beat.utf8_byte = b;
      beat.char_done = last;
      beat.name_done = last & name_end;
      expected_bytes.push_back(beat);
    endfunction

    // encode one accepted mac roman transaction
    function void note_char(logic [7:0] code, logic name_end);
      logic [15:0] cp;
      chars_seen++;
      if (name_end) names_seen++;
      if (code < SPACE_CODE || code == DEL_CODE) begin
        ctrl_chars++;
        push_byte(QMARK_BYTE, 1'b1, name_end);
      end else if (!code[7]) begin
        push_byte(code, 1'b1, name_end);
      end else begin
        cp = MAC_HIGH_CP[code[6:0]];
        if (cp < 16'h0800) begin
          two_byte_chars++;
          push_byte(LEAD2_BYTE | {3'b000, cp[10:6]}, 1'b0, name_end);
          push_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b1, name_end);
        end else begin
          three_byte_chars++;
          push_byte(LEAD3_BYTE | {4'b0000, cp[15:12]}, 1'b0, name_end);
          push_byte(CONT_BYTE | {2'b00, cp[11:6]}, 1'b0, name_end);
          push_byte(CONT_BYTE | {2'b00, cp[5:0]}, 1'b1, name_end);
        end
      end
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // compare one output transaction with the oldest expected byte
    function void check_byte(logic [7:0] b, logic cd, logic nd);
      utf8_beat_t want;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h char_done %0b name_done %0b", b, cd, nd));
        return;
      end
      want = expected_bytes.pop_front();
      if (b !== want.utf8_byte)
        report($sformatf("utf8_byte exp %02h got %02h", want.utf8_byte, b));
      if (cd !== want.char_done)
        report($sformatf("char_done exp %0b got %0b (byte %02h)", want.char_done, cd, b));
      if (nd !== want.name_done)
        report($sformatf("name_done exp %0b got %0b (byte %02h)", want.name_done, nd, b));
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void finish();
      if (expected_bytes.size() != 0)
        report($sformatf("%0d expected bytes never came out", expected_bytes.size()));
    endfunction
  endclass

  utf8_stream_checker chk;
  bit calm = 1'b0;   // no idling on either side
  int rx_hold = 0;   // cycles the receiver still holds off

  // output side: random backpressure plus requested hold-offs
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // sample output transactions
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      chk.check_byte(out_ch.utf8_byte, out_ch.char_done, out_ch.name_done);
  end

  // offer one character, called at a falling edge, returns at a falling edge
  task automatic send_char(input logic [7:0] code, input logic name_end);
    in_ch.valid    <= 1'b1;
    in_ch.mac_byte <= code;
    in_ch.name_end <= name_end;
    do @(posedge clk); while (!in_ch.ready);
    chk.note_char(code, name_end);
    @(negedge clk);
  endtask

  // random input gaps
  task automatic maybe_idle();
    while (!calm && $urandom_range(99) < 34) begin
      in_ch.valid    <= 1'b0;
      in_ch.mac_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
  endtask

  // stop offering until every expected byte is out
  task automatic wait_drained(input int limit);
    int n;
    n = 0;
    in_ch.valid <= 1'b0;
    while (chk.pending() != 0 && n < limit) begin
      @(negedge clk);
      n++;
    end
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return ($urandom_range(7) == 0) ? DEL_CODE : 8'($urandom_range(31));
      2: return 8'($urandom_range(8'h7E, 8'h20));
      default: return 8'($urandom_range(8'hFF, 8'h80));
    endcase
  endfunction

  // directed characters: extremes, control codes, both encodings, special code points
  localparam logic [7:0] DIRECTED [18] = '{
    8'h00, 8'h1F, 8'h20, 8'h3F, 8'h41, 8'h7E, 8'h7F, 8'h80, 8'hA0,
    8'hDB, 8'hDE, 8'hF0, 8'hFF, 8'hB9, 8'hC4, 8'hD9, 8'hAA, 8'h55
  };

  initial begin
    int sent;
    int len;
    bit did_hold;
    bit did_pause;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.mac_byte = 8'h00;
    in_ch.name_end = 1'b0;
    chk = new();
    did_hold = 1'b0;
    did_pause = 1'b0;

    // hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, every other character closes a name
    for (int i = 0; i < 18; i++) begin
      maybe_idle();
      send_char(DIRECTED[i], i[0]);
    end
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    wait_drained(5000);
    @(negedge clk);

    // random names with some noise
    sent = 0;
    while (sent < 360) begin
      calm = (sent >= 140 && sent < 210);

      // long receiver hold-off while the sender keeps pushing
      if (!did_hold && sent >= 60) begin
        did_hold = 1'b1;
        rx_hold = 80;
        for (int i = 0; i < 24; i++) send_char(pick_char(), (i % 6) == 5);
        sent += 24;
      end

      // sender pause until the output is drained
      if (!did_pause && sent >= 250) begin
        did_pause = 1'b1;
        wait_drained(5000);
        @(negedge clk);
      end

      if ($urandom_range(99) < 15) begin
        maybe_idle();
        send_char(pick_char(), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(12, 1);
        for (int i = 0; i < len; i++) begin
          maybe_idle();
          send_char(pick_char(), i == len - 1);
        end
        sent += len;
      end
    end
    calm = 1'b0;

    // drain and let the pipeline settle
    wait_drained(20000);
    repeat (8) @(negedge clk);
    chk.finish();

    $display("covered %0d characters in %0d names: %0d control, %0d two-byte, %0d three-byte",
             chk.chars_seen, chk.names_seen, chk.ctrl_chars, chk.two_byte_chars,
             chk.three_byte_chars);
    $display("checked %0d output bytes with random stalls and a long output hold-off, %0d errors",
             chk.bytes_checked, chk.errors);
    if (chk.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
